// ===== sv/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Fixed-point format, scaling tables, sequencer encodings, unit handshakes
// and the saturating helpers used by the datapath modules.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // fraction bits of the scaled raw values and of the polynomial terms
    localparam int SCALED_FRAC_BITS = 24;

    // scaling divider: quotient digits of DIV_DIGIT_BITS bits, one digit a cycle
    localparam int DIV_DIGIT_BITS = 4;
    localparam int DIV_N_W        = 24 + SCALED_FRAC_BITS;
    localparam int DIV_STEPS      = (SCALED_FRAC_BITS + 11 + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
    localparam int DIV_X_W        = DIV_STEPS * DIV_DIGIT_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

    // scaling factor per oversampling code; factor = divisor << shift
    localparam logic [23:0] SCALE_FACTOR [8] = '{
        24'd524288, 24'd1572864, 24'd3670016, 24'd7864320,
        24'd253952, 24'd516096,  24'd1040384, 24'd2088960
    };
    localparam logic [7:0] SCALE_DIVISOR [8] = '{
        8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
    };
    localparam logic [4:0] SCALE_SHIFT [8] = '{
        5'd19, 5'd19, 5'd19, 5'd19, 5'd13, 5'd13, 5'd13, 5'd13
    };

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // multiply-shift: product high word limit and rounding constant
    localparam logic [63:0] MUL_HI_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF >> (32 - SCALED_FRAC_BITS);
    localparam logic [63:0] MUL_ROUND    = 64'd1 << (SCALED_FRAC_BITS - 1);

    typedef enum logic [2:0] {
        CFG_COEF_LOW,
        CFG_COEF_MID,
        CFG_COEF_HIGH,
        CFG_TEMP_OSR,
        CFG_PRESS_OSR
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_T_DIV,
        ST_T_MAC,
        ST_T_FIN,
        ST_P_DIV,
        ST_P_MAC,
        ST_P_FIN,
        ST_OUT
    } ptc_state_t;

    typedef enum logic [2:0] {
        MAC_IDLE,
        MAC_LO,
        MAC_HI,
        MAC_COMB,
        MAC_ADD
    } mac_state_t;

    // pressure polynomial steps, in issue order
    typedef enum logic [2:0] {
        PS_D,
        PS_E,
        PS_A,
        PS_B,
        PS_T0,
        PS_T1
    } p_step_t;

    typedef struct packed {
        logic        start;
        logic [23:0] raw;
        logic [2:0]  code;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] value;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [31:0] b;
        logic signed [63:0] addend;
    } mac_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] value;
    } mac_rsp_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] x,
                                                     input logic signed [63:0] y);
        logic signed [63:0] s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63])
            return y[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    // drop s fraction bits rounding half away from zero, saturate to 32 bits
    function automatic logic signed [31:0] round_sat32(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        if (s > 0)
            m = (m >> s) + ((m >> (s - 1)) & 64'd1);
        if (v[63])
        begin
            if (m > 64'h0000_0000_8000_0000)
                return S32_MIN;
            return 32'(64'd0 - m);
        end
        if (m > 64'h0000_0000_7FFF_FFFF)
            return S32_MAX;
        return m[31:0];
    endfunction

    function automatic logic signed [63:0] coef_q(input logic signed [63:0] c);
        return c <<< SCALED_FRAC_BITS;
    endfunction

endpackage

// ===== sv/ptc_scale_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_scale_div: raw word scaling divider
// Sign-extends a 24-bit raw word and divides its magnitude, shifted up by the
// fraction bits, by the selected scaling factor with round-half-away. The
// power-of-two part of the factor is a shift; the odd part is divided four
// quotient bits a cycle by restoring long division.
// ----------------------------------------------------------------------------
module ptc_scale_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptc_pkg::div_req_t req,
    output ptc_pkg::div_rsp_t rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [ptc_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ptc_pkg::DIV_X_W-1:0]        x_reg, x_next;
    logic [ptc_pkg::DIV_X_W-1:0]        q_reg, q_next;
    logic [7:0]                         rem_reg, rem_next;
    logic [7:0]                         d_reg, d_next;
    logic                               neg_reg, neg_next;
    logic [31:0]                        q_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        logic [23:0]                  mag;
        logic [ptc_pkg::DIV_N_W-1:0]  n;
        logic [ptc_pkg::DIV_X_W-1:0]  x;
        logic [ptc_pkg::DIV_X_W-1:0]  q;
        logic [7:0]                   rem;
        logic [8:0]                   t;
        logic [8:0]                   diff;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        mag       = '0;
        n         = '0;
        x         = x_reg;
        q         = q_reg;
        rem       = rem_reg;
        t         = '0;
        diff      = '0;

        if (busy_reg)
        begin
            for (int i = 0; i < ptc_pkg::DIV_DIGIT_BITS; i++)
            begin
                t    = {rem, x[ptc_pkg::DIV_X_W-1]};
                x    = x << 1;
                diff = t - {1'b0, d_reg};
                if (t >= {1'b0, d_reg})
                begin
                    rem = diff[7:0];
                    q   = {q[ptc_pkg::DIV_X_W-2:0], 1'b1};
                end
                else
                begin
                    rem = t[7:0];
                    q   = {q[ptc_pkg::DIV_X_W-2:0], 1'b0};
                end
            end
            x_next   = x;
            q_next   = q;
            rem_next = rem;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ptc_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            // fold the half-factor rounding term in, then strip the power of two
            mag       = req.raw[23] ? (24'd0 - req.raw) : req.raw;
            n         = {mag, {ptc_pkg::SCALED_FRAC_BITS{1'b0}}}
                        + ptc_pkg::DIV_N_W'(ptc_pkg::SCALE_FACTOR[req.code] >> 1);
            x_next    = ptc_pkg::DIV_X_W'(n >> ptc_pkg::SCALE_SHIFT[req.code]);
            q_next    = '0;
            rem_next  = '0;
            d_next    = ptc_pkg::SCALE_DIVISOR[req.code];
            neg_next  = req.raw[23];
            cnt_next  = ptc_pkg::DIV_CNT_W'(ptc_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
    end

    assign q_sat = (q_reg > ptc_pkg::DIV_X_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : 32'(q_reg);

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.value = neg_reg ? (32'd0 - q_sat) : q_sat;

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> rem_reg < d_reg)
        else $error("divider remainder not below divisor");

endmodule

// ===== sv/ptc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_mac: shared multiply-shift-accumulate unit
// Computes sat_add(addend, round(a * b / 2^F)) with one 32x32 unsigned
// multiplier used twice on the halves of |a|, then a saturating combine
// and a saturating add, one step a cycle.
// ----------------------------------------------------------------------------
module ptc_mac
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptc_pkg::mac_req_t req,
    output ptc_pkg::mac_rsp_t rsp
);

    localparam int SHL = 32 - ptc_pkg::SCALED_FRAC_BITS;

    ptc_pkg::mac_state_t state_reg, state_next;
    logic                done_reg, done_next;
    logic [63:0]         ma_reg, ma_next;
    logic [31:0]         mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic signed [63:0]  addend_reg, addend_next;
    logic [63:0]         lo_reg, lo_next;
    logic [63:0]         hi_reg, hi_next;
    logic signed [63:0]  term_reg, term_next;
    logic signed [63:0]  result_reg, result_next;
    logic [31:0]         mul_a;
    logic [63:0]         prod;

    // the one multiplier, fed a half of |a| at a time
    assign mul_a = (state_reg == ptc_pkg::MAC_HI) ? ma_reg[63:32] : ma_reg[31:0];
    assign prod  = mul_a * mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptc_pkg::MAC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        neg_reg    <= neg_next;
        addend_reg <= addend_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        term_reg   <= term_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        logic [63:0] lo_r;
        logic [63:0] r;

        state_next  = state_reg;
        done_next   = 1'b0;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        neg_next    = neg_reg;
        addend_next = addend_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        term_next   = term_reg;
        result_next = result_reg;
        lo_r        = '0;
        r           = '0;

        case (state_reg)
            ptc_pkg::MAC_IDLE:
            begin
                if (req.start)
                begin
                    ma_next     = req.a[63] ? (64'd0 - req.a) : req.a;
                    mb_next     = req.b[31] ? (32'd0 - req.b) : req.b;
                    neg_next    = req.a[63] ^ req.b[31];
                    addend_next = req.addend;
                    state_next  = ptc_pkg::MAC_LO;
                end
            end
            ptc_pkg::MAC_LO:
            begin
                lo_next    = prod;
                state_next = ptc_pkg::MAC_HI;
            end
            ptc_pkg::MAC_HI:
            begin
                hi_next    = prod;
                state_next = ptc_pkg::MAC_COMB;
            end
            ptc_pkg::MAC_COMB:
            begin
                // round, realign the two partial products, clamp to 64 bits
                lo_r = lo_reg + ptc_pkg::MUL_ROUND;
                if (hi_reg > ptc_pkg::MUL_HI_LIMIT)
                    r = 64'h8000_0000_0000_0000;
                else
                    r = (hi_reg << SHL) + (lo_r >> ptc_pkg::SCALED_FRAC_BITS);
                if (r[63])
                    term_next = neg_reg ? ptc_pkg::S64_MIN : ptc_pkg::S64_MAX;
                else
                    term_next = neg_reg ? (64'd0 - r) : r;
                state_next = ptc_pkg::MAC_ADD;
            end
            ptc_pkg::MAC_ADD:
            begin
                result_next = ptc_pkg::sat_add64(addend_reg, term_reg);
                done_next   = 1'b1;
                state_next  = ptc_pkg::MAC_IDLE;
            end
            default:
            begin
                state_next = ptc_pkg::MAC_IDLE;
            end
        endcase
    end

    assign rsp.busy  = (state_reg != ptc_pkg::MAC_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.value = result_reg;

endmodule

// ===== sv/pressure_temp_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation: barometric sensor polynomial compensation
// One poll in, one transaction out: temperature Q16.16 and pressure Q24.8
// from calibration coefficients, held raw words and the latest scaled value.
// ----------------------------------------------------------------------------
// A poll with neither ready flag goes straight to output; temperature takes one
// division and one multiplier term, pressure one division and six terms.
// s_tready is high only while idle; the result register lets the next poll start
// early. Reset clears the control, held-value and result state to zero, but not
// the pressure operand, saved branch or output data registers.
// ----------------------------------------------------------------------------
module pressure_temp_compensation
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // raw_temp [23:0], raw_press [47:24]
    input  logic [1:0]   s_tuser,   // temp_ready [0], press_ready [1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // temp_value [31:0], press_value [63:32],
                                    // raw_temp_out [87:64], raw_press_out [111:88]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    localparam int F = ptc_pkg::SCALED_FRAC_BITS;

    // configuration
    logic [63:0] coef_low_reg;
    logic [63:0] coef_mid_reg;
    logic [15:0] coef_high_reg;
    logic [2:0]  temp_osr_reg;
    logic [2:0]  press_osr_reg;

    ptc_pkg::ptc_state_t state_reg, state_next;
    ptc_pkg::p_step_t    step_reg, step_next;
    logic                issued_reg, issued_next;
    logic                p_rdy_reg, p_rdy_next;
    logic [23:0]         raw_temp_hold_reg, raw_temp_hold_next;
    logic [23:0]         raw_press_hold_reg, raw_press_hold_next;
    logic signed [31:0]  scaled_temp_reg, scaled_temp_next;
    logic signed [31:0]  ps_reg, ps_next;
    logic signed [63:0]  save_reg, save_next;
    logic signed [31:0]  temp_res_reg, temp_res_next;
    logic signed [31:0]  press_res_reg, press_res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [111:0]        m_tdata_reg, m_tdata_next;

    logic signed [11:0]  c0, c1;
    logic signed [19:0]  c00, c10;
    logic signed [15:0]  c01, c11, c20, c21, c30;

    logic                div_start;
    logic                mac_start;
    ptc_pkg::div_req_t   div_req;
    ptc_pkg::div_rsp_t   div_rsp;
    ptc_pkg::mac_req_t   mac_req;
    ptc_pkg::mac_rsp_t   mac_rsp;

    // calibration fields, the first (c0) in the top bits
    assign c0  = coef_low_reg[63:52];
    assign c1  = coef_low_reg[51:40];
    assign c00 = coef_low_reg[39:20];
    assign c10 = coef_low_reg[19:0];
    assign c01 = coef_mid_reg[63:48];
    assign c11 = coef_mid_reg[47:32];
    assign c20 = coef_mid_reg[31:16];
    assign c21 = coef_mid_reg[15:0];
    assign c30 = coef_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_low_reg  <= '0;
            coef_mid_reg  <= '0;
            coef_high_reg <= '0;
            temp_osr_reg  <= '0;
            press_osr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ptc_pkg::CFG_COEF_LOW:  coef_low_reg  <= cfg_wdata;
                ptc_pkg::CFG_COEF_MID:  coef_mid_reg  <= cfg_wdata;
                ptc_pkg::CFG_COEF_HIGH: coef_high_reg <= cfg_wdata[15:0];
                ptc_pkg::CFG_TEMP_OSR:  temp_osr_reg  <= cfg_wdata[2:0];
                ptc_pkg::CFG_PRESS_OSR: press_osr_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ptc_pkg::ST_IDLE;
            step_reg           <= ptc_pkg::PS_D;
            issued_reg         <= 1'b0;
            p_rdy_reg          <= 1'b0;
            raw_temp_hold_reg  <= '0;
            raw_press_hold_reg <= '0;
            scaled_temp_reg    <= '0;
            temp_res_reg       <= '0;
            press_res_reg      <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            step_reg           <= step_next;
            issued_reg         <= issued_next;
            p_rdy_reg          <= p_rdy_next;
            raw_temp_hold_reg  <= raw_temp_hold_next;
            raw_press_hold_reg <= raw_press_hold_next;
            scaled_temp_reg    <= scaled_temp_next;
            temp_res_reg       <= temp_res_next;
            press_res_reg      <= press_res_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg      <= ps_next;
        save_reg    <= save_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ptc_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        step_next           = step_reg;
        issued_next         = issued_reg;
        p_rdy_next          = p_rdy_reg;
        raw_temp_hold_next  = raw_temp_hold_reg;
        raw_press_hold_next = raw_press_hold_reg;
        scaled_temp_next    = scaled_temp_reg;
        ps_next             = ps_reg;
        save_next           = save_reg;
        temp_res_next       = temp_res_reg;
        press_res_next      = press_res_reg;
        m_tvalid_next       = m_tvalid_reg;
        m_tdata_next        = m_tdata_reg;
        div_start           = 1'b0;
        mac_start           = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ptc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    p_rdy_next  = s_tuser[1];
                    issued_next = 1'b0;
                    if (s_tuser[0])
                        raw_temp_hold_next = s_tdata[23:0];
                    if (s_tuser[1])
                        raw_press_hold_next = s_tdata[47:24];
                    if (s_tuser[0])
                        state_next = ptc_pkg::ST_T_DIV;
                    else if (s_tuser[1])
                        state_next = ptc_pkg::ST_P_DIV;
                    else
                        state_next = ptc_pkg::ST_OUT;
                end
            end
            ptc_pkg::ST_T_DIV:
            begin
                if (!issued_reg)
                begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    scaled_temp_next = div_rsp.value;
                    issued_next      = 1'b0;
                    state_next       = ptc_pkg::ST_T_MAC;
                end
            end
            ptc_pkg::ST_T_MAC:
            begin
                if (!issued_reg)
                begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mac_rsp.done)
                begin
                    issued_next = 1'b0;
                    state_next  = ptc_pkg::ST_T_FIN;
                end
            end
            ptc_pkg::ST_T_FIN:
            begin
                temp_res_next = ptc_pkg::round_sat32(mac_rsp.value, F - 16);
                state_next    = p_rdy_reg ? ptc_pkg::ST_P_DIV : ptc_pkg::ST_OUT;
            end
            ptc_pkg::ST_P_DIV:
            begin
                if (!issued_reg)
                begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    ps_next     = div_rsp.value;
                    step_next   = ptc_pkg::PS_D;
                    issued_next = 1'b0;
                    state_next  = ptc_pkg::ST_P_MAC;
                end
            end
            ptc_pkg::ST_P_MAC:
            begin
                if (!issued_reg)
                begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mac_rsp.done)
                begin
                    issued_next = 1'b0;
                    // park the temperature branch while the pressure chain runs
                    if (step_reg == ptc_pkg::PS_E)
                        save_next = mac_rsp.value;
                    if (step_reg == ptc_pkg::PS_T1)
                        state_next = ptc_pkg::ST_P_FIN;
                    else
                        step_next = ptc_pkg::p_step_t'(step_reg + 3'd1);
                end
            end
            ptc_pkg::ST_P_FIN:
            begin
                press_res_next = ptc_pkg::round_sat32(mac_rsp.value, F - 8);
                state_next     = ptc_pkg::ST_OUT;
            end
            ptc_pkg::ST_OUT:
            begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {raw_press_hold_reg, raw_temp_hold_reg,
                                     press_res_reg, temp_res_reg};
                    state_next    = ptc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptc_pkg::ST_IDLE;
            end
        endcase
    end

    // divider operands
    always_comb
    begin
        div_req.start = div_start;
        if (state_reg == ptc_pkg::ST_T_DIV)
        begin
            div_req.raw  = raw_temp_hold_reg;
            div_req.code = temp_osr_reg;
        end
        else
        begin
            div_req.raw  = raw_press_hold_reg;
            div_req.code = press_osr_reg;
        end
    end

    // multiplier operands: Horner chain, temperature branch first
    always_comb
    begin
        mac_req.start  = mac_start;
        mac_req.a      = mac_rsp.value;
        mac_req.b      = ps_reg;
        mac_req.addend = mac_rsp.value;
        if (state_reg == ptc_pkg::ST_T_MAC)
        begin
            mac_req.a      = ptc_pkg::coef_q(64'(c1));
            mac_req.b      = scaled_temp_reg;
            mac_req.addend = 64'(c0) <<< (F - 1);
        end
        else
        begin
            case (step_reg)
                ptc_pkg::PS_D:
                begin
                    mac_req.a      = ptc_pkg::coef_q(64'(c21));
                    mac_req.addend = ptc_pkg::coef_q(64'(c11));
                end
                ptc_pkg::PS_E:
                begin
                    mac_req.addend = ptc_pkg::coef_q(64'(c01));
                end
                ptc_pkg::PS_A:
                begin
                    mac_req.a      = ptc_pkg::coef_q(64'(c30));
                    mac_req.addend = ptc_pkg::coef_q(64'(c20));
                end
                ptc_pkg::PS_B:
                begin
                    mac_req.addend = ptc_pkg::coef_q(64'(c10));
                end
                ptc_pkg::PS_T0:
                begin
                    mac_req.addend = ptc_pkg::coef_q(64'(c00));
                end
                ptc_pkg::PS_T1:
                begin
                    mac_req.a = save_reg;
                    mac_req.b = scaled_temp_reg;
                end
                default:
                begin
                    mac_req.a = mac_rsp.value;
                end
            endcase
        end
    end

    ptc_scale_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ptc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_rsp.busy && !mac_rsp.busy)
        else $error("poll accepted while a shared unit is busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ptc_pkg::ST_T_DIV || state_reg == ptc_pkg::ST_P_DIV))
        else $error("division finished outside a division step");

    assert property (@(posedge clk) disable iff (!rst_n)
        mac_rsp.done |-> (state_reg == ptc_pkg::ST_T_MAC || state_reg == ptc_pkg::ST_P_MAC))
        else $error("multiply finished outside a polynomial step");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == 2'b00 |=> state_reg == ptc_pkg::ST_OUT)
        else $error("poll with no fresh word did not go straight to output");

endmodule

// ===== bench/pressure_temp_compensation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation_tb: self-checking bench for the compensation block
// Polls go in on the slave stream, calibration and oversampling codes through
// the write port. A bit-exact model of the scaling and polynomial arithmetic
// predicts each output transaction, which is checked field by field. Directed
// polls cover reset, raw and coefficient extremes and every oversampling code;
// random polls follow under random idling, output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_tb;

    typedef struct {
        logic signed [31:0] temp_value;
        logic signed [31:0] press_value;
        logic [23:0]        raw_temp;
        logic [23:0]        raw_press;
    } reading_t;

    localparam longint LONG_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LONG_MIN   = 64'sh8000_0000_0000_0000;
    localparam longint S32_TOP    = 64'sd2147483647;
    localparam longint S32_BOTTOM = -64'sd2147483648;
    localparam longint ONE_Q      = 64'sd1 << ptc_pkg::SCALED_FRAC_BITS;

    localparam logic [23:0] OSR_FACTOR [8] = '{
        24'd524288, 24'd1572864, 24'd3670016, 24'd7864320,
        24'd253952, 24'd516096,  24'd1040384, 24'd2088960
    };

    // no register lives at this index; writes to it must change nothing
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int IDLE_PERCENT    = 6;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;     // raw_temp [23:0], raw_press [47:24]
    logic [1:0]   s_tuser = '0;     // temp_ready [0], press_ready [1]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // temp_value [31:0], press_value [63:32],
                                    // raw_temp_out [87:64], raw_press_out [111:88]
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_wdata = '0;

    // shadow of the configuration and of the held values
    logic [63:0]        coef_low = '0;
    logic [63:0]        coef_mid = '0;
    logic [15:0]        coef_high = '0;
    logic [2:0]         temp_code = '0;
    logic [2:0]         press_code = '0;
    logic signed [31:0] held_scaled_temp = '0;
    logic signed [31:0] held_temp_value = '0;
    logic signed [31:0] held_press_value = '0;
    logic [23:0]        held_raw_temp = '0;
    logic [23:0]        held_raw_press = '0;

    reading_t expected_readings [$];
    int       error_count = 0;
    int       quiet_cycles = 0;
    bit       sender_idles = 1'b1;
    bit       receiver_idles = 1'b1;
    bit       hold_off_req = 1'b0;

    pressure_temp_compensation dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point arithmetic of the compensation
    // ------------------------------------------------------------------------
    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(bit neg, logic [63:0] m);
        if (m > 64'h7FFF_FFFF_FFFF_FFFF)
            return neg ? LONG_MIN : LONG_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint add_clamped(longint x, longint y);
        logic signed [64:0] s;
        s = 65'(x) + 65'(y);
        if (s > 65'(LONG_MAX))
            return LONG_MAX;
        if (s < 65'(LONG_MIN))
            return LONG_MIN;
        return longint'(s[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > S32_TOP)
            return 32'sh7FFF_FFFF;
        if (v < S32_BOTTOM)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // drop s fraction bits, rounding half away from zero
    function automatic longint round_drop(longint v, int unsigned s);
        logic [63:0] m;
        m = magnitude(v);
        if (s > 0)
            m = (m >> s) + ((m >> (s - 1)) & 64'd1);
        return signed_of(v < 0, m);
    endfunction

    // (a * b) / 2^F, rounded, saturated to 64 bits
    function automatic longint scaled_product(longint a, logic signed [31:0] b);
        logic [127:0] p;
        p = 128'(magnitude(a)) * 128'(magnitude(longint'(b)));
        p = (p + (128'd1 << (ptc_pkg::SCALED_FRAC_BITS - 1))) >> ptc_pkg::SCALED_FRAC_BITS;
        return signed_of((a < 0) != (b < 0),
                         (p[127:64] != '0) ? 64'h8000_0000_0000_0000 : p[63:0]);
    endfunction

    function automatic logic signed [31:0] scale_raw_word(logic [23:0] raw,
                                                          logic [2:0] code);
        longint      r;
        logic [63:0] f;
        logic [63:0] q;
        r = longint'($signed(raw));
        f = 64'(OSR_FACTOR[code]);
        q = ((magnitude(r) << ptc_pkg::SCALED_FRAC_BITS) + (f >> 1)) / f;
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return 32'(signed_of(r < 0, q));
    endfunction

    // advance the held state by one poll and queue the reading it produces
    task automatic compensate_poll(bit t_rdy, bit p_rdy,
                                   logic [23:0] rt, logic [23:0] rp);
        longint             c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint             acc, a, b, d, e, tot;
        logic signed [31:0] ps;
        reading_t           r;
        c0  = longint'($signed(coef_low[63:52]));
        c1  = longint'($signed(coef_low[51:40]));
        c00 = longint'($signed(coef_low[39:20]));
        c10 = longint'($signed(coef_low[19:0]));
        c01 = longint'($signed(coef_mid[63:48]));
        c11 = longint'($signed(coef_mid[47:32]));
        c20 = longint'($signed(coef_mid[31:16]));
        c21 = longint'($signed(coef_mid[15:0]));
        c30 = longint'($signed(coef_high));
        // temperature first, so pressure sees this poll's temperature
        if (t_rdy)
        begin
            held_raw_temp = rt;
            held_scaled_temp = scale_raw_word(rt, temp_code);
            acc = longint'(held_scaled_temp) * c1 + c0 * (ONE_Q / 2);
            held_temp_value = clamp32(round_drop(acc, ptc_pkg::SCALED_FRAC_BITS - 16));
        end
        if (p_rdy)
        begin
            held_raw_press = rp;
            ps = scale_raw_word(rp, press_code);
            a = c20 * ONE_Q + c30 * longint'(ps);
            b = add_clamped(c10 * ONE_Q, scaled_product(a, ps));
            d = c11 * ONE_Q + c21 * longint'(ps);
            e = add_clamped(c01 * ONE_Q, scaled_product(d, ps));
            tot = add_clamped(c00 * ONE_Q, scaled_product(b, ps));
            tot = add_clamped(tot, scaled_product(e, held_scaled_temp));
            held_press_value = clamp32(round_drop(tot, ptc_pkg::SCALED_FRAC_BITS - 8));
        end
        r.temp_value  = held_temp_value;
        r.press_value = held_press_value;
        r.raw_temp    = held_raw_temp;
        r.raw_press   = held_raw_press;
        expected_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_poll(bit t_rdy, bit p_rdy, logic [23:0] rt, logic [23:0] rp);
        if (sender_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rp, rt};
        s_tuser  <= {p_rdy, t_rdy};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        compensate_poll(t_rdy, p_rdy, rt, rp);
    endtask

    function automatic logic [23:0] pick_raw();
        logic signed [16:0] near_zero;
        near_zero = 17'($urandom);
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: return 24'h000000;
                    1: return 24'h7FFFFF;
                    2: return 24'h800000;
                    default: return 24'hFFFFFF;
                endcase
            end
            1, 2, 3: return 24'(near_zero);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random_polls(int count);
        logic [1:0] flags;
        repeat (count)
        begin
            flags = 2'($urandom_range(3));
            send_poll(flags[0], flags[1], pick_raw(), pick_raw());
        end
    endtask

    // stop offering polls and wait for every outstanding reading
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            ptc_pkg::CFG_COEF_LOW:  coef_low = value;
            ptc_pkg::CFG_COEF_MID:  coef_mid = value;
            ptc_pkg::CFG_COEF_HIGH: coef_high = value[15:0];
            ptc_pkg::CFG_TEMP_OSR:  temp_code = value[2:0];
            ptc_pkg::CFG_PRESS_OSR: press_code = value[2:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_calibration(logic [63:0] low, logic [63:0] mid, logic [15:0] high);
        write_reg(ptc_pkg::CFG_COEF_LOW, low);
        write_reg(ptc_pkg::CFG_COEF_MID, mid);
        write_reg(ptc_pkg::CFG_COEF_HIGH, {48'd0, high});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        send_poll(1'b0, 1'b0, 24'h5A5A5A, 24'hA5A5A5);
        send_poll(1'b1, 1'b0, 24'h123456, 24'h000000);
        send_poll(1'b0, 1'b1, 24'h000000, 24'hABCDEF);
        send_poll(1'b1, 1'b1, 24'hFEDCBA, 24'h654321);
    endtask

    task automatic test_calibration_extremes();
        drain_results();
        load_calibration(64'h0D3F_1C2A_B37E_49F1, 64'hF3A2_0C41_FD18_0357, 16'hFE9B);
        write_reg(ptc_pkg::CFG_TEMP_OSR, 64'd3);
        write_reg(ptc_pkg::CFG_PRESS_OSR, 64'd6);
        send_poll(1'b1, 1'b1, 24'h000000, 24'h000000);
        send_poll(1'b1, 1'b1, 24'h7FFFFF, 24'h7FFFFF);
        send_poll(1'b1, 1'b1, 24'h800000, 24'h800000);
        send_poll(1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
        send_poll(1'b0, 1'b1, 24'h000000, 24'h3FA210);
        send_poll(1'b1, 1'b0, 24'hF01234, 24'h000000);
        // every coefficient at its largest positive value
        drain_results();
        load_calibration(64'h7FF7_FF7F_FFF7_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        send_poll(1'b1, 1'b1, 24'h7FFFFF, 24'h800000);
        send_poll(1'b1, 1'b1, 24'h800000, 24'h7FFFFF);
        // every coefficient at its most negative value
        drain_results();
        load_calibration(64'h8008_0080_0008_0000, 64'h8000_8000_8000_8000, 16'h8000);
        send_poll(1'b1, 1'b1, 24'h7FFFFF, 24'h7FFFFF);
        send_poll(1'b1, 1'b1, 24'h800000, 24'h800000);
        // all ones: every coefficient at minus one
        drain_results();
        load_calibration(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_poll(1'b1, 1'b1, 24'h400000, 24'hC00000);
        // a write to an unmapped index must leave the configuration alone
        drain_results();
        write_reg(CFG_UNMAPPED, 64'h0123_4567_89AB_CDEF);
        send_poll(1'b1, 1'b1, 24'h2468AC, 24'hDB9753);
    endtask

    task automatic test_oversample_codes();
        drain_results();
        load_calibration(64'h0C8F_E31A_6B2D_F0C4, 64'hE1F3_0042_FC11_0021, 16'hFFD5);
        for (int code = 0; code < 8; code++)
        begin
            drain_results();
            write_reg(ptc_pkg::CFG_TEMP_OSR, 64'(code));
            write_reg(ptc_pkg::CFG_PRESS_OSR, 64'(7 - code));
            send_poll(1'b1, 1'b1, pick_raw(), pick_raw());
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++)
        begin
            drain_results();
            load_calibration({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
            write_reg(ptc_pkg::CFG_TEMP_OSR, 64'($urandom_range(7)));
            write_reg(ptc_pkg::CFG_PRESS_OSR, 64'($urandom_range(7)));
            send_random_polls(100);
        end
    endtask

    task automatic test_back_to_back();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        send_random_polls(150);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // hold the output off for a long stretch while polls keep coming
    task automatic test_output_stall();
        hold_off_req = 1'b1;
        send_random_polls(40);
    endtask

    task automatic test_sender_pause();
        send_random_polls(20);
        drain_results();
        send_random_polls(20);
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("output transaction with no poll outstanding: 0x%028h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("temp_value", want.temp_value, m_tdata[31:0]);
                check_field("press_value", want.press_value, m_tdata[63:32]);
                check_field("raw_temp_out", 32'(want.raw_temp), 32'(m_tdata[87:64]));
                check_field("raw_press_out", 32'(want.raw_press), 32'(m_tdata[111:88]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_calibration_extremes();
        test_oversample_codes();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        test_sender_pause();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
